// File: hdl/tmcpg_pkg.sv
// Shared constants, codes and reset tables of the text-mode character pixel generator.
package tmcpg_pkg;

	// Screen geometry.
	localparam int COLUMNS      = 32;
	localparam int ROWS         = 12;
	localparam int BORDER_WIDTH = 6;

	localparam int CELL_COUNT  = COLUMNS * ROWS;
	localparam int FONT_WORDS  = 256;
	localparam int PAL_ENTRIES = 16;
	localparam int AREA_W      = COLUMNS * 4;
	localparam int AREA_H      = ROWS * 8;

	// Address widths of the stores.
	localparam int SCR_AW  = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
	localparam int FONT_AW = $clog2(FONT_WORDS);
	localparam int PAL_AW  = $clog2(PAL_ENTRIES);

	// The clearing pass after reset covers the larger of screen and font.
	localparam int CLR_LEN = (CELL_COUNT > FONT_WORDS) ? CELL_COUNT : FONT_WORDS;
	localparam int CLR_W   = $clog2(CLR_LEN + 1);

	// Item operation codes.
	localparam logic [2:0] OP_SCREEN_WR  = 3'd0;
	localparam logic [2:0] OP_FONT_WR    = 3'd1;
	localparam logic [2:0] OP_PALETTE_WR = 3'd2;
	localparam logic [2:0] OP_TICK       = 3'd3;
	localparam logic [2:0] OP_PIXEL      = 3'd4;

	// Configuration register indexes.
	localparam logic CFG_BORDER_INDEX = 1'b0;
	localparam logic CFG_BLINK_PERIOD = 1'b1;

	localparam logic [15:0] BLINK_PERIOD_RST = 16'd800;
	localparam logic [7:0]  ALPHA_OPAQUE     = 8'hff;

	// Default palette, 0x0RGB nibbles.
	localparam logic [11:0] PAL_INIT [PAL_ENTRIES] = '{
		12'h000, 12'h00a, 12'h0a0, 12'h0aa, 12'ha00, 12'ha0a, 12'ha50, 12'haaa,
		12'h555, 12'h55f, 12'h5f5, 12'h5ff, 12'hf55, 12'hf5f, 12'hff5, 12'hfff
	};

	// Default font: two words per 4x8 glyph.
	localparam logic [15:0] FONT_INIT [FONT_WORDS] = '{
		16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
		16'h242e, 16'h2400, 16'h082a, 16'h0800, 16'h0008, 16'h0000, 16'h0808, 16'h0808,
		16'h00ff, 16'h0000, 16'h00f8, 16'h0808, 16'h08f8, 16'h0000, 16'h080f, 16'h0000,
		16'h000f, 16'h0808, 16'h00ff, 16'h0808, 16'h08f8, 16'h0808, 16'h08ff, 16'h0000,
		16'h080f, 16'h0808, 16'h08ff, 16'h0808, 16'h6633, 16'h99cc, 16'h9933, 16'h66cc,
		16'hfef8, 16'he080, 16'h7f1f, 16'h0701, 16'h0107, 16'h1f7f, 16'h80e0, 16'hf8fe,
		16'h5500, 16'haa00, 16'h55aa, 16'h55aa, 16'hffaa, 16'hff55, 16'h0f0f, 16'h0f0f,
		16'hf0f0, 16'hf0f0, 16'h0000, 16'hffff, 16'hffff, 16'h0000, 16'hffff, 16'hffff,
		16'h0000, 16'h0000, 16'h005f, 16'h0000, 16'h0300, 16'h0300, 16'h3e14, 16'h3e00,
		16'h266b, 16'h3200, 16'h611c, 16'h4300, 16'h3629, 16'h7650, 16'h0002, 16'h0100,
		16'h1c22, 16'h4100, 16'h4122, 16'h1c00, 16'h1408, 16'h1400, 16'h081c, 16'h0800,
		16'h4020, 16'h0000, 16'h0808, 16'h0800, 16'h0040, 16'h0000, 16'h601c, 16'h0300,
		16'h3e49, 16'h3e00, 16'h427f, 16'h4000, 16'h6259, 16'h4600, 16'h2249, 16'h3600,
		16'h0f08, 16'h7f00, 16'h2745, 16'h3900, 16'h3e49, 16'h3200, 16'h6119, 16'h0700,
		16'h3649, 16'h3600, 16'h2649, 16'h3e00, 16'h0024, 16'h0000, 16'h4024, 16'h0000,
		16'h0814, 16'h2241, 16'h1414, 16'h1400, 16'h4122, 16'h1408, 16'h0259, 16'h0600,
		16'h3e59, 16'h5e00, 16'h7e09, 16'h7e00, 16'h7f49, 16'h3600, 16'h3e41, 16'h2200,
		16'h7f41, 16'h3e00, 16'h7f49, 16'h4100, 16'h7f09, 16'h0100, 16'h3e41, 16'h7a00,
		16'h7f08, 16'h7f00, 16'h417f, 16'h4100, 16'h2040, 16'h3f00, 16'h7f08, 16'h7700,
		16'h7f40, 16'h4000, 16'h7f06, 16'h7f00, 16'h7f01, 16'h7e00, 16'h3e41, 16'h3e00,
		16'h7f09, 16'h0600, 16'h3e41, 16'hbe00, 16'h7f09, 16'h7600, 16'h2649, 16'h3200,
		16'h017f, 16'h0100, 16'h3f40, 16'h3f00, 16'h1f60, 16'h1f00, 16'h7f30, 16'h7f00,
		16'h7708, 16'h7700, 16'h0778, 16'h0700, 16'h7149, 16'h4700, 16'h007f, 16'h4100,
		16'h031c, 16'h6000, 16'h0041, 16'h7f00, 16'h0201, 16'h0200, 16'h8080, 16'h8000,
		16'h0001, 16'h0200, 16'h2454, 16'h7800, 16'h7f44, 16'h3800, 16'h3844, 16'h2800,
		16'h3844, 16'h7f00, 16'h3854, 16'h5800, 16'h087e, 16'h0900, 16'h4854, 16'h3c00,
		16'h7f04, 16'h7800, 16'h447d, 16'h4000, 16'h2040, 16'h3d00, 16'h7f10, 16'h6c00,
		16'h417f, 16'h4000, 16'h7c18, 16'h7c00, 16'h7c04, 16'h7800, 16'h3844, 16'h3800,
		16'h7c14, 16'h0800, 16'h0814, 16'h7c00, 16'h7c04, 16'h0800, 16'h4854, 16'h2400,
		16'h043e, 16'h4400, 16'h3c40, 16'h7c00, 16'h1c60, 16'h1c00, 16'h7c30, 16'h7c00,
		16'h6c10, 16'h6c00, 16'h4c50, 16'h3c00, 16'h6454, 16'h4c00, 16'h0836, 16'h4100,
		16'h0077, 16'h0000, 16'h4136, 16'h0800, 16'h0201, 16'h0201, 16'h0205, 16'h0200
	};

	// Expand a 0x0RGB palette word to RGBA with opaque alpha.
	function automatic logic [31:0] expand_colour(input logic [11:0] c);
		return {ALPHA_OPAQUE, c[3:0], c[3:0], c[7:4], c[7:4], c[11:8], c[11:8]};
	endfunction

endpackage

// File: hdl/tmcpg_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module tmcpg_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                                          clk,
	input  logic                                          we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                              wdata,
	input  logic                                          re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                              rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port; data holds while no read is issued.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: hdl/text_mode_character_pixel_generator_top.sv
// Top level of the text-mode character pixel generator.
//
// Items enter on the input channel (in_valid, in_stall, op, addr, wdata, pix_x,
// pix_y) and pixel colors leave on the output channel (out_valid, out_stall,
// pixel_rgba). A beat moves when valid is high and stall is low.
// Screen, font and palette writes and blink ticks give no result. A pixel
// request reads the screen RAM, then the font RAM and both palette RAM
// copies, and its color is registered in the output register after stage 2. While
// a request is in those two stages the input stalls, so a new pixel request
// waits until it is through; writes and ticks go at one per cycle otherwise.
// When the receiver stalls, the finished color waits in the output register and
// further writes and ticks are still taken; a following pixel request waits in
// its last stage until the output register frees.
// After reset a clearing pass over 384 entries zeroes the screen and loads the
// default font and palette, one entry a cycle; the input stalls meanwhile.
// The configuration port (cfg_we, cfg_index, cfg_wdata) writes border_index or
// blink_period, as cfg_index selects, and is taken at any time.
module text_mode_character_pixel_generator_top import tmcpg_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// Input channel.
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  op,
	input  logic [8:0]  addr,
	input  logic [15:0] wdata,
	input  logic [7:0]  pix_x,
	input  logic [6:0]  pix_y,
	// Output channel.
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] pixel_rgba,
	// Configuration port.
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_wdata
);

	// Control and configuration registers.
	logic             clr_done;
	logic [CLR_W-1:0] clr_q;
	logic [3:0]       border_index_q;
	logic [15:0]      blink_period_q;
	logic [15:0]      blink_count_q;
	logic             blink_phase_q;
	logic             out_valid_q;
	logic [31:0]      pixel_rgba_q;

	// Pipeline of a pixel request.
	logic       valid_s1;
	logic       border_s1;
	logic       cx1_s1;
	logic       cx0_s1;
	logic [2:0] cy_s1;
	logic       valid_s2;
	logic       border_s2;
	logic       blank_s2;
	logic       cx0_s2;
	logic [2:0] cy_s2;

	// Front-end decode.
	logic              accept;
	logic              in_area;
	logic [7:0]        cx;
	logic [6:0]        cy;
	logic [SCR_AW-1:0] cell_addr;
	logic [15:0]       tick_count;

	// RAM ports.
	logic               scr_we;
	logic [SCR_AW-1:0]  scr_waddr;
	logic [15:0]        scr_wdata;
	logic               scr_re;
	logic [15:0]        cell_word;
	logic               font_we;
	logic [FONT_AW-1:0] font_waddr;
	logic [15:0]        font_wdata;
	logic [FONT_AW-1:0] font_raddr;
	logic [15:0]        font_word;
	logic               pal_we;
	logic [PAL_AW-1:0]  pal_waddr;
	logic [11:0]        pal_wdata;
	logic [PAL_AW-1:0]  pal_bg_raddr;
	logic [PAL_AW-1:0]  pal_fg_raddr;
	logic [11:0]        pal_bg;
	logic [11:0]        pal_fg;

	// Back end.
	logic       s2_done;
	logic       glyph_bit;
	logic [7:0] glyph_row;

	// Handshake.
	assign clr_done  = (clr_q == CLR_W'(CLR_LEN));
	assign in_stall  = !clr_done || valid_s1 || valid_s2;
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign pixel_rgba = pixel_rgba_q;

	// Clearing pass after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (!clr_done) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			border_index_q <= '0;
			blink_period_q <= BLINK_PERIOD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_BORDER_INDEX: border_index_q <= cfg_wdata[3:0];
				CFG_BLINK_PERIOD: blink_period_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Blink timer.
	assign tick_count = blink_count_q + 16'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blink_count_q <= '0;
			blink_phase_q <= 1'b0;
		end else if (accept && op == OP_TICK) begin
			if (tick_count >= blink_period_q) begin
				blink_count_q <= '0;
				blink_phase_q <= !blink_phase_q;
			end else begin
				blink_count_q <= tick_count;
			end
		end
	end

	// Pixel coordinates relative to the character area.
	always_comb begin
		in_area = (int'(pix_x) >= BORDER_WIDTH) && (int'(pix_x) < BORDER_WIDTH + AREA_W) &&
			(int'(pix_y) >= BORDER_WIDTH) && (int'(pix_y) < BORDER_WIDTH + AREA_H);
		cx = 8'(int'(pix_x) - BORDER_WIDTH);
		cy = 7'(int'(pix_y) - BORDER_WIDTH);
		cell_addr = SCR_AW'(int'(cy[6:3]) * COLUMNS + int'(cx[7:2]));
	end

	// Store write ports: the clearing pass owns them until it finishes.
	always_comb begin
		scr_we     = 1'b0;
		scr_waddr  = SCR_AW'(addr);
		scr_wdata  = wdata;
		font_we    = 1'b0;
		font_waddr = addr[FONT_AW-1:0];
		font_wdata = wdata;
		pal_we     = 1'b0;
		pal_waddr  = addr[PAL_AW-1:0];
		pal_wdata  = wdata[11:0];
		if (!clr_done) begin
			scr_we     = (int'(clr_q) < CELL_COUNT);
			scr_waddr  = clr_q[SCR_AW-1:0];
			scr_wdata  = '0;
			font_we    = (int'(clr_q) < FONT_WORDS);
			font_waddr = clr_q[FONT_AW-1:0];
			font_wdata = FONT_INIT[clr_q[FONT_AW-1:0]];
			pal_we     = (int'(clr_q) < PAL_ENTRIES);
			pal_waddr  = clr_q[PAL_AW-1:0];
			pal_wdata  = PAL_INIT[clr_q[PAL_AW-1:0]];
		end else if (accept) begin
			case (op)
				OP_SCREEN_WR:  scr_we  = (int'(addr) < CELL_COUNT);
				OP_FONT_WR:    font_we = (int'(addr) < FONT_WORDS);
				OP_PALETTE_WR: pal_we  = (int'(addr) < PAL_ENTRIES);
				default: ;
			endcase
		end
	end

	assign scr_re = accept && op == OP_PIXEL;

	// Stage 1 register: request position within its cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= scr_re;
		end
	end

	always_ff @(posedge clk) begin
		if (scr_re) begin
			border_s1 <= !in_area;
			cx1_s1    <= cx[1];
			cx0_s1    <= cx[0];
			cy_s1     <= cy[2:0];
		end
	end

	// Cell lookup: glyph word and both colors are read together.
	assign font_raddr   = {cell_word[6:0], cx1_s1};
	assign pal_bg_raddr = border_s1 ? border_index_q : cell_word[11:8];
	assign pal_fg_raddr = cell_word[15:12];

	// Stage 2 register; it holds while the output register is full and stalled.
	assign s2_done = valid_s2 && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (valid_s1) begin
			valid_s2 <= 1'b1;
		end else if (s2_done) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			border_s2 <= border_s1;
			blank_s2  <= cell_word[7] && blink_phase_q;
			cx0_s2    <= cx0_s1;
			cy_s2     <= cy_s1;
		end
	end

	// Glyph bit: high byte for even columns, low byte for odd ones.
	assign glyph_row = cx0_s2 ? font_word[7:0] : font_word[15:8];
	assign glyph_bit = glyph_row[cy_s2] && !border_s2 && !blank_s2;

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s2_done) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_done) begin
			pixel_rgba_q <= expand_colour(glyph_bit ? pal_fg : pal_bg);
		end
	end

	// Stores.
	tmcpg_ram #(.WIDTH(16), .DEPTH(CELL_COUNT)) u_screen_ram (
		.clk   (clk),
		.we    (scr_we),
		.waddr (scr_waddr),
		.wdata (scr_wdata),
		.re    (scr_re),
		.raddr (cell_addr),
		.rdata (cell_word)
	);

	tmcpg_ram #(.WIDTH(16), .DEPTH(FONT_WORDS)) u_font_ram (
		.clk   (clk),
		.we    (font_we),
		.waddr (font_waddr),
		.wdata (font_wdata),
		.re    (valid_s1),
		.raddr (font_raddr),
		.rdata (font_word)
	);

	// Two palette copies give the background and foreground in one read.
	tmcpg_ram #(.WIDTH(12), .DEPTH(PAL_ENTRIES)) u_pal_bg_ram (
		.clk   (clk),
		.we    (pal_we),
		.waddr (pal_waddr),
		.wdata (pal_wdata),
		.re    (valid_s1),
		.raddr (pal_bg_raddr),
		.rdata (pal_bg)
	);

	tmcpg_ram #(.WIDTH(12), .DEPTH(PAL_ENTRIES)) u_pal_fg_ram (
		.clk   (clk),
		.we    (pal_we),
		.waddr (pal_waddr),
		.wdata (pal_wdata),
		.re    (valid_s1),
		.raddr (pal_fg_raddr),
		.rdata (pal_fg)
	);

	// Only one pixel request is ever in flight.
	assert property (@(posedge clk) disable iff (!arst_n) !(valid_s1 && valid_s2))
		else $error("two pixel requests in flight");

	// No item is taken before the stores are initialized.
	assert property (@(posedge clk) disable iff (!arst_n) accept |-> clr_done)
		else $error("item accepted during the clearing pass");

	// A request in stage 1 always moves on to stage 2.
	assert property (@(posedge clk) disable iff (!arst_n) valid_s1 |=> valid_s2)
		else $error("stage 1 request lost");

	// A finished request waits while the output register is blocked.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && out_valid_q && out_stall |=> valid_s2)
		else $error("stage 2 request dropped under stall");

	// A completed request shows up at the output.
	assert property (@(posedge clk) disable iff (!arst_n) s2_done |=> out_valid_q)
		else $error("completed pixel not presented");

endmodule
